### sv/nml_pkg.sv
package nml_pkg;

  localparam int TICK_CYCLES = 4;
  localparam int TW    = 21;
  localparam int HW    = TW + 1;
  localparam int DW    = 9;
  localparam int LANES = 4;
  localparam logic [23:0] LAT_MAX = 24'hFFFFFF;

  localparam logic [2:0] MODE_NONE      = 3'd0;
  localparam logic [2:0] MODE_MESH_SHRT = 3'd1;
  localparam logic [2:0] MODE_MESH_RAND = 3'd2;
  localparam logic [2:0] MODE_CLOS_SHRT = 3'd3;
  localparam logic [2:0] MODE_CLOS_RAND = 3'd4;

  localparam logic [2:0] CFG_MODEL      = 3'd0;
  localparam logic [2:0] CFG_TPC        = 3'd1;
  localparam logic [2:0] CFG_TPS        = 3'd2;
  localparam logic [2:0] CFG_SWX        = 3'd3;
  localparam logic [2:0] CFG_CHX        = 3'd4;
  localparam logic [2:0] CFG_CORES      = 3'd5;
  localparam logic [2:0] CFG_COST       = 3'd6;
  localparam logic [2:0] CFG_CONTENTION = 3'd7;

  localparam int COST_THREAD  = 0;
  localparam int COST_TOKEN   = 1;
  localparam int COST_TSWITCH = 2;
  localparam int COST_LINK_ON = 3;
  localparam int COST_LINK_OFF = 4;
  localparam int COST_SERIAL  = 5;
  localparam int COST_SWITCH  = 6;
  localparam int COST_CLOSED  = 7;

  localparam logic [2:0] CORES_256 = 3'd2;
  localparam logic [2:0] CORES_4K  = 3'd6;

  localparam logic [1:0] KIND_ZERO   = 2'd0;
  localparam logic [1:0] KIND_THREAD = 2'd1;
  localparam logic [1:0] KIND_HOPS   = 2'd2;

  typedef logic [TW-1:0] word_t;
  typedef logic [DW-1:0] dvs_t;

  typedef struct packed {
    logic [2:0]  model;
    logic [8:0]  tpc;
    logic [8:0]  tps;
    logic [6:0]  swx;
    logic [4:0]  chx;
    logic [2:0]  cores;
    logic [63:0] cost;
    logic [15:0] cf;
  } cfg_t;

  typedef struct packed {
    word_t       s;
    word_t       t;
    word_t       ssw;
    word_t       tsw;
    word_t       sc;
    word_t       tc;
    logic [9:0]  ntok;
    logic        route_open;
  } ctx_t;

  typedef struct packed {
    logic [1:0]    kind;
    logic          err;
    logic [HW-1:0] on;
    logic [HW-1:0] off;
    logic [9:0]    ntok;
    logic          route_open;
  } hop_t;

  function automatic logic [7:0] cost_byte(logic [63:0] tbl, int k);
    return tbl[8*k +: 8];
  endfunction

  function automatic dvs_t nz(dvs_t v);
    return (v == '0) ? dvs_t'(1) : v;
  endfunction

  function automatic word_t absdiff(word_t a, word_t b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [4:0] rand_on(logic [2:0] code);
    case (code)
      3'd2: return 5'd5;
      3'd3: return 5'd6;
      3'd4: return 5'd8;
      3'd5: return 5'd12;
      3'd6: return 5'd20;
      default: return 5'd0;
    endcase
  endfunction

  function automatic logic [2:0] rand_off(logic [2:0] code);
    case (code)
      3'd3: return 3'd1;
      3'd4: return 3'd2;
      3'd5: return 3'd3;
      3'd6: return 3'd6;
      default: return 3'd0;
    endcase
  endfunction

endpackage

### sv/nml_if.sv
interface nml_msg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  source_core;
  logic [15:0] source_node;
  logic [7:0]  target_core;
  logic [15:0] target_node;
  logic [9:0]  token_count;
  logic        route_open;
  modport source(output valid, source_core, source_node, target_core, target_node,
                 token_count, route_open, input ready);
  modport sink(input valid, source_core, source_node, target_core, target_node,
               token_count, route_open, output ready);
endinterface

interface nml_res_if;
  logic        valid;
  logic        ready;
  logic [23:0] latency_cycles;
  logic        config_error;
  modport source(output valid, latency_cycles, config_error, input ready);
  modport sink(input valid, latency_cycles, config_error, output ready);
endinterface

interface nml_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### sv/nml_cfg.sv
module nml_cfg (
  input  logic            clk_i,
  input  logic            rst_ni,
  nml_cfg_if.sink         cfg_i,
  output nml_pkg::cfg_t   cfg_o
);

  nml_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        nml_pkg::CFG_MODEL:      cfg_d.model = cfg_i.data[2:0];
        nml_pkg::CFG_TPC:        cfg_d.tpc   = cfg_i.data[8:0];
        nml_pkg::CFG_TPS:        cfg_d.tps   = cfg_i.data[8:0];
        nml_pkg::CFG_SWX:        cfg_d.swx   = cfg_i.data[6:0];
        nml_pkg::CFG_CHX:        cfg_d.chx   = cfg_i.data[4:0];
        nml_pkg::CFG_CORES:      cfg_d.cores = cfg_i.data[2:0];
        nml_pkg::CFG_COST:       cfg_d.cost  = cfg_i.data;
        nml_pkg::CFG_CONTENTION: cfg_d.cf    = cfg_i.data[15:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.model <= nml_pkg::MODE_NONE;
      cfg_q.tpc   <= 9'd256;
      cfg_q.tps   <= 9'd16;
      cfg_q.swx   <= 7'd4;
      cfg_q.chx   <= 5'd1;
      cfg_q.cores <= nml_pkg::CORES_256;
      cfg_q.cost  <= '0;
      cfg_q.cf    <= 16'd256;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### sv/nml_div.sv
module nml_div (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           vld_i,
  input  nml_pkg::word_t dividend_i [nml_pkg::LANES],
  input  nml_pkg::dvs_t  divisor_i  [nml_pkg::LANES],
  input  nml_pkg::ctx_t  ctx_i,
  output logic           vld_o,
  output nml_pkg::word_t quo_o [nml_pkg::LANES],
  output nml_pkg::dvs_t  rem_o [nml_pkg::LANES],
  output nml_pkg::ctx_t  ctx_o
);

  localparam int ST = nml_pkg::TW;

  nml_pkg::word_t work_q [ST][nml_pkg::LANES];
  nml_pkg::dvs_t  rem_q  [ST][nml_pkg::LANES];
  nml_pkg::word_t work_d [ST][nml_pkg::LANES];
  nml_pkg::dvs_t  rem_d  [ST][nml_pkg::LANES];
  nml_pkg::ctx_t  ctx_q  [ST];
  logic           vld_q  [ST];

  // one quotient bit per stage, restoring
  always_comb begin
    nml_pkg::word_t         w;
    nml_pkg::dvs_t          r;
    logic [nml_pkg::DW:0]   tmp;
    logic [nml_pkg::DW:0]   sub;
    logic                   ge;
    for (int st = 0; st < ST; st++) begin
      for (int ln = 0; ln < nml_pkg::LANES; ln++) begin
        if (st == 0) begin
          w = dividend_i[ln];
          r = '0;
        end else begin
          w = work_q[st-1][ln];
          r = rem_q[st-1][ln];
        end
        tmp = {r, w[nml_pkg::TW-1]};
        sub = tmp - {1'b0, divisor_i[ln]};
        ge  = tmp >= {1'b0, divisor_i[ln]};
        rem_d[st][ln]  = ge ? sub[nml_pkg::DW-1:0] : tmp[nml_pkg::DW-1:0];
        work_d[st][ln] = {w[nml_pkg::TW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int st = 0; st < ST; st++) begin
        work_q[st] <= work_d[st];
        rem_q[st]  <= rem_d[st];
        ctx_q[st]  <= (st == 0) ? ctx_i : ctx_q[(st == 0) ? 0 : st-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int st = 0; st < ST; st++) vld_q[st] <= 1'b0;
    end else if (en_i) begin
      for (int st = 0; st < ST; st++) begin
        vld_q[st] <= (st == 0) ? vld_i : vld_q[(st == 0) ? 0 : st-1];
      end
    end
  end

  assign vld_o = vld_q[ST-1];
  assign quo_o = work_q[ST-1];
  assign rem_o = rem_q[ST-1];
  assign ctx_o = ctx_q[ST-1];

endmodule

### sv/nml_cost.sv
module nml_cost (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  nml_pkg::cfg_t cfg_i,
  input  logic          vld_i,
  input  nml_pkg::hop_t hop_i,
  output logic          en_o,
  nml_res_if.source     res_o
);

  logic vd_q, ve_q, vo_q;

  // products
  logic [1:0]  kind_d_q;
  logic        err_d_q;
  logic [17:0] p_tok_q;
  logic [29:0] p_on_q, p_off_q;
  logic [30:0] p_cl_q, p_sw_q;
  logic [7:0]  ser_q;
  logic [8:0]  ts2_q;

  logic [nml_pkg::HW:0] h, h1;
  assign h  = {1'b0, hop_i.on} + {1'b0, hop_i.off};
  assign h1 = h + 1'b1;

  // sum and contention scaling
  logic [1:0]  kind_e_q;
  logic        err_e_q;
  logic [39:0] whole_q;
  logic [46:0] frac_q;

  // rounding and tick scaling
  logic [55:0] total;
  logic [47:0] ticks;
  logic [52:0] cyc;
  logic [23:0] lat;

  logic [23:0] lat_q;
  logic        err_q;

  assign en_o = !vo_q || res_o.ready;

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      kind_d_q <= hop_i.kind;
      err_d_q  <= hop_i.err;
      p_tok_q  <= hop_i.ntok * nml_pkg::cost_byte(cfg_i.cost, nml_pkg::COST_TOKEN);
      p_on_q   <= hop_i.on * nml_pkg::cost_byte(cfg_i.cost, nml_pkg::COST_LINK_ON);
      p_off_q  <= hop_i.off * nml_pkg::cost_byte(cfg_i.cost, nml_pkg::COST_LINK_OFF);
      p_cl_q   <= hop_i.route_open ? '0 :
                  h1 * nml_pkg::cost_byte(cfg_i.cost, nml_pkg::COST_CLOSED);
      p_sw_q   <= h1 * nml_pkg::cost_byte(cfg_i.cost, nml_pkg::COST_SWITCH);
      ser_q    <= (h != '0) ? nml_pkg::cost_byte(cfg_i.cost, nml_pkg::COST_SERIAL) : 8'd0;
      ts2_q    <= {nml_pkg::cost_byte(cfg_i.cost, nml_pkg::COST_TSWITCH), 1'b0};

      kind_e_q <= kind_d_q;
      err_e_q  <= err_d_q;
      whole_q  <= 40'(p_tok_q) + 40'(p_on_q) + 40'(p_off_q) + 40'(p_cl_q)
                + 40'(ser_q) + 40'(ts2_q);
      frac_q   <= p_sw_q * cfg_i.cf;

      lat_q <= lat;
      err_q <= err_e_q;
    end
  end

  always_comb begin
    total = {8'd0, whole_q, 8'd0} + 56'(frac_q) + 56'd255;
    ticks = total[55:8];
    if (kind_e_q == nml_pkg::KIND_THREAD) begin
      ticks = 48'(nml_pkg::cost_byte(cfg_i.cost, nml_pkg::COST_THREAD));
    end
    cyc = 53'(ticks) * 53'(nml_pkg::TICK_CYCLES);
    lat = (cyc > 53'(nml_pkg::LAT_MAX)) ? nml_pkg::LAT_MAX : cyc[23:0];
    if (kind_e_q == nml_pkg::KIND_ZERO) lat = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en_o) begin
      vd_q <= vld_i;
      ve_q <= vd_q;
      vo_q <= ve_q;
    end
  end

  assign res_o.valid          = vo_q;
  assign res_o.latency_cycles = lat_q;
  assign res_o.config_error   = err_q;

endmodule

### sv/network_message_latency.sv
// Message latency pipeline. One message is taken per cycle and passes
// through the stages in order: one stage forms the tile ids, two 21-stage
// bit-per-cycle dividers find switch, chip and grid coordinates, one stage
// counts hops, and three stages weigh the hops by cost, scale the switch
// cost by the contention factor, round up to ticks and saturate. The whole
// pipeline holds while a finished result is not taken. Configuration must
// only be written while the pipeline is empty.
module network_message_latency (
  input  logic      clk_i,
  input  logic      rst_ni,
  nml_msg_if.sink   msg_i,
  nml_res_if.source res_o,
  nml_cfg_if.sink   cfg_i
);

  nml_pkg::cfg_t cfg;
  logic          en;

  nml_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  assign msg_i.ready = en;

  // tile ids
  nml_pkg::ctx_t  ctx0_d, ctx0_q;
  logic           vld0_q;
  nml_pkg::word_t s_mul, t_mul;

  always_comb begin
    s_mul = msg_i.source_node[15:4] * cfg.tpc;
    t_mul = msg_i.target_node[15:4] * cfg.tpc;
    ctx0_d            = '0;
    ctx0_d.s          = s_mul + nml_pkg::TW'(msg_i.source_core);
    ctx0_d.t          = t_mul + nml_pkg::TW'(msg_i.target_core);
    ctx0_d.ntok       = msg_i.token_count;
    ctx0_d.route_open = msg_i.route_open;
  end

  always_ff @(posedge clk_i) begin
    if (en) ctx0_q <= ctx0_d;
  end

  // switch and chip index
  nml_pkg::word_t div_a_n [nml_pkg::LANES];
  nml_pkg::dvs_t  div_a_d [nml_pkg::LANES];
  nml_pkg::word_t quo_a   [nml_pkg::LANES];
  nml_pkg::dvs_t  rem_a   [nml_pkg::LANES];
  nml_pkg::ctx_t  ctx_a;
  logic           vld_a;

  assign div_a_n = '{ctx0_q.s, ctx0_q.t, ctx0_q.s, ctx0_q.t};
  assign div_a_d = '{nml_pkg::nz(cfg.tps), nml_pkg::nz(cfg.tps),
                     nml_pkg::nz(cfg.tpc), nml_pkg::nz(cfg.tpc)};

  nml_div u_div_a (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .vld_i      (vld0_q),
    .dividend_i (div_a_n),
    .divisor_i  (div_a_d),
    .ctx_i      (ctx0_q),
    .vld_o      (vld_a),
    .quo_o      (quo_a),
    .rem_o      (rem_a),
    .ctx_o      (ctx_a)
  );

  // grid coordinates
  nml_pkg::ctx_t  ctx_b_in, ctx_b;
  nml_pkg::dvs_t  div_b_d [nml_pkg::LANES];
  nml_pkg::word_t quo_b   [nml_pkg::LANES];
  nml_pkg::dvs_t  rem_b   [nml_pkg::LANES];
  logic           vld_b;

  always_comb begin
    ctx_b_in     = ctx_a;
    ctx_b_in.ssw = quo_a[0];
    ctx_b_in.tsw = quo_a[1];
    ctx_b_in.sc  = quo_a[2];
    ctx_b_in.tc  = quo_a[3];
  end

  assign div_b_d = '{nml_pkg::nz({2'b0, cfg.swx}), nml_pkg::nz({2'b0, cfg.swx}),
                     nml_pkg::nz({4'b0, cfg.chx}), nml_pkg::nz({4'b0, cfg.chx})};

  nml_div u_div_b (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .vld_i      (vld_a),
    .dividend_i (quo_a),
    .divisor_i  (div_b_d),
    .ctx_i      (ctx_b_in),
    .vld_o      (vld_b),
    .quo_o      (quo_b),
    .rem_o      (rem_b),
    .ctx_o      (ctx_b)
  );

  // hop count
  nml_pkg::hop_t  hop_d, hop_q;
  logic           vldc_q;
  logic           err;
  nml_pkg::word_t offx, offy, swdx, swdy;
  logic [nml_pkg::HW-1:0] pos, neg;

  always_comb begin
    err = (cfg.model > nml_pkg::MODE_CLOS_RAND)
       || ((cfg.model == nml_pkg::MODE_MESH_RAND || cfg.model == nml_pkg::MODE_CLOS_RAND)
           && cfg.cores > nml_pkg::CORES_4K)
       || (cfg.model == nml_pkg::MODE_MESH_RAND && cfg.cores < nml_pkg::CORES_256);
    offx = nml_pkg::absdiff(nml_pkg::TW'(rem_b[2]), nml_pkg::TW'(rem_b[3]));
    offy = nml_pkg::absdiff(quo_b[2], quo_b[3]);
    swdx = nml_pkg::absdiff(nml_pkg::TW'(rem_b[0]), nml_pkg::TW'(rem_b[1]));
    swdy = nml_pkg::absdiff(quo_b[0], quo_b[1]);
    pos  = {1'b0, swdx} + {1'b0, swdy};
    neg  = {1'b0, offx} + {1'b0, offy};

    hop_d            = '0;
    hop_d.err        = err;
    hop_d.ntok       = ctx_b.ntok;
    hop_d.route_open = ctx_b.route_open;
    if (err || cfg.model == nml_pkg::MODE_NONE) begin
      hop_d.kind = nml_pkg::KIND_ZERO;
    end else if (ctx_b.s == ctx_b.t) begin
      hop_d.kind = nml_pkg::KIND_THREAD;
    end else begin
      hop_d.kind = nml_pkg::KIND_HOPS;
      if (ctx_b.ssw != ctx_b.tsw) begin
        case (cfg.model)
          nml_pkg::MODE_MESH_SHRT: begin
            hop_d.off = neg;
            hop_d.on  = (pos > neg) ? pos - neg : '0;
          end
          nml_pkg::MODE_MESH_RAND: begin
            hop_d.on  = nml_pkg::HW'(nml_pkg::rand_on(cfg.cores));
            hop_d.off = nml_pkg::HW'(nml_pkg::rand_off(cfg.cores));
          end
          nml_pkg::MODE_CLOS_SHRT: begin
            hop_d.on  = nml_pkg::HW'(2);
            hop_d.off = (ctx_b.sc == ctx_b.tc) ? '0 : nml_pkg::HW'(2);
          end
          default: begin
            hop_d.on  = nml_pkg::HW'(2);
            hop_d.off = (cfg.cores <= nml_pkg::CORES_256) ? '0 : nml_pkg::HW'(2);
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) hop_q <= hop_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
      vldc_q <= 1'b0;
    end else if (en) begin
      vld0_q <= msg_i.valid;
      vldc_q <= vld_b;
    end
  end

  nml_cost u_cost (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .vld_i  (vldc_q),
    .hop_i  (hop_q),
    .en_o   (en),
    .res_o  (res_o)
  );

`ifndef NO_ASSERTIONS
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.config_error |-> res_o.latency_cycles == '0)
    else $error("error result with nonzero latency");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && cfg.model == nml_pkg::MODE_NONE |->
      res_o.latency_cycles == '0 && !res_o.config_error)
    else $error("mode none gave a latency");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    msg_i.ready == (!res_o.valid || res_o.ready))
    else $error("input ready does not follow output stall");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vldc_q && !en |=> vldc_q && $stable(hop_q))
    else $error("hop stage lost data during stall");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_a |-> rem_a[0] < div_a_d[0] && rem_a[1] < div_a_d[1]
           && rem_a[2] < div_a_d[2] && rem_a[3] < div_a_d[3])
    else $error("divider remainder out of range");
`endif

endmodule

### tb/tb_network_message_latency.sv
module tb_network_message_latency;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0]  src_core;
    logic [15:0] src_node;
    logic [7:0]  dst_core;
    logic [15:0] dst_node;
    logic [9:0]  tokens;
    logic        open_route;
  } message_t;

  typedef struct {
    logic [23:0] latency;
    logic        error;
  } latency_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  nml_msg_if msg();
  nml_res_if res();
  nml_cfg_if cfg();

  network_message_latency uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .msg_i (msg),
    .res_o (res),
    .cfg_i (cfg)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // shadow of the block's registers
  logic [2:0]  m_model;
  logic [8:0]  m_tpc, m_tps;
  logic [6:0]  m_swx;
  logic [4:0]  m_chx;
  logic [2:0]  m_cores;
  logic [63:0] m_cost;
  logic [15:0] m_cf;

  message_t pending_msgs[$];
  latency_t expected_latencies[$];
  int errors = 0;
  int sent = 0;
  int checked = 0;
  bit calm = 1'b0;

  function automatic longint unsigned cost_of(int k);
    return longint'(m_cost[8*k +: 8]);
  endfunction

  function automatic longint unsigned one_if_zero(longint unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic longint unsigned abs_gap(longint unsigned a, longint unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic longint unsigned hop_ticks(longint unsigned on, longint unsigned off,
                                                longint unsigned ntok, bit open_r);
    longint unsigned h, whole, frac;
    h = on + off;
    whole = cost_of(nml_pkg::COST_TOKEN) * ntok + 2 * cost_of(nml_pkg::COST_TSWITCH)
          + on * cost_of(nml_pkg::COST_LINK_ON) + off * cost_of(nml_pkg::COST_LINK_OFF)
          + ((h > 0) ? cost_of(nml_pkg::COST_SERIAL) : 0);
    if (!open_r) whole += (h + 1) * cost_of(nml_pkg::COST_CLOSED);
    frac = (h + 1) * cost_of(nml_pkg::COST_SWITCH) * longint'(m_cf);
    return (whole * 256 + frac + 255) >> 8;
  endfunction

  function automatic latency_t predict_latency(message_t m);
    latency_t r;
    longint unsigned s, t, tps, tpc, swx, chx, ssw, tsw, sc, tc, on, off, ticks, cyc;
    longint unsigned px;
    bit err;
    s = longint'(m.src_node >> 4) * longint'(m_tpc) + longint'(m.src_core);
    t = longint'(m.dst_node >> 4) * longint'(m_tpc) + longint'(m.dst_core);
    tps = one_if_zero(m_tps);
    tpc = one_if_zero(m_tpc);
    swx = one_if_zero(m_swx);
    chx = one_if_zero(m_chx);
    ticks = 0;
    on = 0;
    off = 0;
    err = 1'b0;
    if (m_model > nml_pkg::MODE_CLOS_RAND) err = 1'b1;
    else if ((m_model == nml_pkg::MODE_MESH_RAND || m_model == nml_pkg::MODE_CLOS_RAND)
             && m_cores > nml_pkg::CORES_4K)
      err = 1'b1;
    else if (m_model == nml_pkg::MODE_MESH_RAND && m_cores < nml_pkg::CORES_256) err = 1'b1;
    if (!err && m_model != nml_pkg::MODE_NONE) begin
      ssw = s / tps;
      tsw = t / tps;
      if (s == t) begin
        ticks = cost_of(nml_pkg::COST_THREAD);
      end else if (ssw == tsw) begin
        ticks = hop_ticks(0, 0, m.tokens, m.open_route);
      end else begin
        case (m_model)
          nml_pkg::MODE_MESH_SHRT: begin
            sc = s / tpc;
            tc = t / tpc;
            off = abs_gap(sc % chx, tc % chx) + abs_gap(sc / chx, tc / chx);
            px = abs_gap(ssw % swx, tsw % swx) + abs_gap(ssw / swx, tsw / swx);
            on = (px > off) ? px - off : 0;
          end
          nml_pkg::MODE_MESH_RAND: begin
            case (m_cores)
              3'd2: begin on = 5; off = 0; end
              3'd3: begin on = 6; off = 1; end
              3'd4: begin on = 8; off = 2; end
              3'd5: begin on = 12; off = 3; end
              default: begin on = 20; off = 6; end
            endcase
          end
          nml_pkg::MODE_CLOS_SHRT: begin
            on = 2;
            off = (s / tpc == t / tpc) ? 0 : 2;
          end
          default: begin
            on = 2;
            off = (m_cores <= nml_pkg::CORES_256) ? 0 : 2;
          end
        endcase
        ticks = hop_ticks(on, off, m.tokens, m.open_route);
      end
    end
    cyc = (ticks > longint'(nml_pkg::LAT_MAX)) ? longint'(nml_pkg::LAT_MAX)
                                               : ticks * nml_pkg::TICK_CYCLES;
    if (cyc > longint'(nml_pkg::LAT_MAX)) cyc = longint'(nml_pkg::LAT_MAX);
    r.latency = cyc[23:0];
    r.error = err;
    return r;
  endfunction

  // message driver
  always @(posedge clk_i) begin
    message_t m;
    bit go;
    if (msg.valid && msg.ready) begin
      expected_latencies.push_back(predict_latency(pending_msgs.pop_front()));
      sent++;
    end
    if (!msg.valid || msg.ready) begin
      go = (pending_msgs.size() > 0) && (calm || $urandom_range(99) >= 12);
      if (go) begin
        m = pending_msgs[0];
        msg.source_core <= m.src_core;
        msg.source_node <= m.src_node;
        msg.target_core <= m.dst_core;
        msg.target_node <= m.dst_node;
        msg.token_count <= m.tokens;
        msg.route_open  <= m.open_route;
      end
      msg.valid <= go;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    latency_t e;
    if (res.valid && res.ready) begin
      if (expected_latencies.size() == 0) begin
        $display("%0t: unexpected result latency=%0d err=%0b", $realtime,
                 res.latency_cycles, res.config_error);
        errors++;
      end else begin
        e = expected_latencies.pop_front();
        checked++;
        if (res.latency_cycles !== e.latency) begin
          $display("%0t: latency mismatch expected %0d actual %0d", $realtime,
                   e.latency, res.latency_cycles);
          errors++;
        end
        if (res.config_error !== e.error) begin
          $display("%0t: config_error mismatch expected %0b actual %0b", $realtime,
                   e.error, res.config_error);
          errors++;
        end
      end
    end
    res.ready <= calm || ($urandom_range(99) >= 12);
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    @(posedge clk_i);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    case (idx)
      nml_pkg::CFG_MODEL:      m_model = data[2:0];
      nml_pkg::CFG_TPC:        m_tpc = data[8:0];
      nml_pkg::CFG_TPS:        m_tps = data[8:0];
      nml_pkg::CFG_SWX:        m_swx = data[6:0];
      nml_pkg::CFG_CHX:        m_chx = data[4:0];
      nml_pkg::CFG_CORES:      m_cores = data[2:0];
      nml_pkg::CFG_COST:       m_cost = data;
      nml_pkg::CFG_CONTENTION: m_cf = data[15:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (pending_msgs.size() != 0 || msg.valid || expected_latencies.size() != 0);
  endtask

  task automatic set_all(logic [2:0] model, logic [8:0] tpc, logic [8:0] tps, logic [6:0] swx,
                         logic [4:0] chx, logic [2:0] cores, logic [63:0] cost,
                         logic [15:0] cf);
    write_reg(nml_pkg::CFG_MODEL, 64'(model));
    write_reg(nml_pkg::CFG_TPC, 64'(tpc));
    write_reg(nml_pkg::CFG_TPS, 64'(tps));
    write_reg(nml_pkg::CFG_SWX, 64'(swx));
    write_reg(nml_pkg::CFG_CHX, 64'(chx));
    write_reg(nml_pkg::CFG_CORES, 64'(cores));
    write_reg(nml_pkg::CFG_COST, cost);
    write_reg(nml_pkg::CFG_CONTENTION, 64'(cf));
  endtask

  task automatic add_msg(int sc, int sn, int tc, int tn, int tok, bit op);
    message_t m;
    m.src_core = 8'(sc);
    m.src_node = 16'(sn);
    m.dst_core = 8'(tc);
    m.dst_node = 16'(tn);
    m.tokens = 10'(tok);
    m.open_route = op;
    pending_msgs.push_back(m);
  endtask

  // mostly tiles inside a small system, some fully random
  task automatic add_random_msg();
    message_t m;
    int chips, tiles;
    chips = $urandom_range(7);
    tiles = (m_tpc == 0) ? 1 : int'(m_tpc);
    if ($urandom_range(3) == 0) begin
      m.src_core = 8'($urandom);
      m.src_node = 16'($urandom);
      m.dst_core = 8'($urandom);
      m.dst_node = 16'($urandom);
    end else begin
      m.src_core = 8'($urandom_range(tiles > 256 ? 255 : tiles - 1));
      m.src_node = 16'(($urandom_range(chips) << 4) | $urandom_range(15));
      m.dst_core = 8'($urandom_range(tiles > 256 ? 255 : tiles - 1));
      m.dst_node = 16'(($urandom_range(chips) << 4) | $urandom_range(15));
      if ($urandom_range(9) == 0) begin
        m.dst_core = m.src_core;
        m.dst_node = m.src_node;
      end
    end
    m.tokens = ($urandom_range(4) == 0) ? 10'($urandom_range(1023)) : 10'($urandom_range(8));
    m.open_route = 1'($urandom);
    pending_msgs.push_back(m);
  endtask

  initial begin
    int p;
    logic [63:0] big;
    msg.valid = 1'b0;
    msg.source_core = '0;
    msg.source_node = '0;
    msg.target_core = '0;
    msg.target_node = '0;
    msg.token_count = '0;
    msg.route_open = 1'b0;
    res.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    m_model = nml_pkg::MODE_NONE;
    m_tpc = 9'd256;
    m_tps = 9'd16;
    m_swx = 7'd4;
    m_chx = 5'd1;
    m_cores = nml_pkg::CORES_256;
    m_cost = '0;
    m_cf = 16'd256;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings, mode none
    add_msg(0, 0, 255, 65535, 1023, 0);
    add_msg(255, 65535, 0, 0, 0, 1);
    drain();

    set_all(nml_pkg::MODE_MESH_SHRT, 9'd16, 9'd4, 7'd8, 5'd2, nml_pkg::CORES_256,
            64'h0807060504030201, 16'd256);
    add_msg(3, 0, 3, 0, 5, 0);        // same tile
    add_msg(0, 0, 2, 0, 5, 0);        // same switch
    add_msg(0, 0, 15, 16, 7, 0);      // neighbor chip
    add_msg(5, 48, 10, 0, 1023, 1);
    add_msg(255, 65535, 0, 0, 1023, 0);
    drain();

    // saturation and max contention
    set_all(nml_pkg::MODE_MESH_RAND, 9'd256, 9'd1, 7'd64, 5'd16, nml_pkg::CORES_4K,
            64'hFFFFFFFFFFFFFFFF, 16'hFFFF);
    add_msg(0, 0, 1, 0, 1023, 0);
    add_msg(0, 65535, 255, 0, 1023, 0);
    drain();

    // zero divisors
    set_all(nml_pkg::MODE_MESH_SHRT, 9'd0, 9'd0, 7'd0, 5'd0, 3'd3,
            64'h1122334455667788, 16'd0);
    add_msg(1, 0, 9, 32, 3, 0);
    add_msg(9, 16, 9, 16, 3, 1);
    drain();
    write_reg(nml_pkg::CFG_MODEL, 64'(nml_pkg::MODE_CLOS_SHRT));
    add_msg(1, 0, 9, 32, 3, 0);
    drain();

    // unsupported core counts and modes
    write_reg(nml_pkg::CFG_MODEL, 64'(nml_pkg::MODE_MESH_RAND));
    write_reg(nml_pkg::CFG_CORES, 64'd1);
    add_msg(0, 0, 1, 0, 1, 0);
    add_msg(0, 0, 0, 0, 1, 0);
    drain();
    write_reg(nml_pkg::CFG_MODEL, 64'(nml_pkg::MODE_CLOS_RAND));
    write_reg(nml_pkg::CFG_CORES, 64'd7);
    add_msg(0, 0, 200, 64, 1, 0);
    drain();
    write_reg(nml_pkg::CFG_MODEL, 64'd7);
    add_msg(0, 0, 200, 64, 1, 0);
    drain();
    write_reg(nml_pkg::CFG_MODEL, 64'd5);
    add_msg(0, 0, 200, 64, 1, 1);
    drain();

    for (p = 0; p < 16; p++) begin
      calm = (p == 5);
      big = {$urandom, $urandom};
      if (p % 4 == 1) big = big & 64'h0F0F0F0F0F0F0F0F;
      set_all(3'(p % 8),
              (p % 5 == 0) ? 9'd256 : (p % 5 == 1) ? 9'd1 : 9'($urandom_range(256, 1)),
              (p % 3 == 0) ? 9'd1 : (p % 3 == 1) ? 9'd256 : 9'($urandom_range(64, 1)),
              (p % 4 == 0) ? 7'd64 : (p % 4 == 1) ? 7'd1 : 7'($urandom_range(64, 1)),
              (p % 4 == 2) ? 5'd16 : (p % 4 == 3) ? 5'd1 : 5'($urandom_range(16, 1)),
              (p < 8) ? 3'($urandom_range(6)) : 3'($urandom_range(7)),
              big,
              (p % 6 == 0) ? 16'hFFFF : (p % 6 == 1) ? 16'd256 : 16'($urandom));
      // mesh modes get more traffic so different switches and chips show up
      repeat ((p % 8 == 1 || p % 8 == 2) ? 110 : 65) add_random_msg();
      drain();
    end
    calm = 1'b0;

    repeat (100) @(posedge clk_i);
    $display("sent %0d messages over all five models, bad modes and core counts", sent);
    $display("checked %0d latencies, %0d mismatches", checked, errors);
    if (errors == 0 && expected_latencies.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

### network_message_latency.f
sv/nml_pkg.sv
sv/nml_if.sv
sv/nml_cfg.sv
sv/nml_div.sv
sv/nml_cost.sv
sv/network_message_latency.sv
tb/tb_network_message_latency.sv
